// File: hw/rtl/ale_pkg.sv
// List engine package: command, status, state codes; command, result types.
// No dependencies.
package ale_pkg;
  typedef enum logic [2:0] {
    CMD_SEARCH = 3'd0, CMD_INSERT = 3'd1, CMD_DELETE = 3'd2,
    CMD_REMOVE = 3'd3, CMD_FREQ = 3'd4, CMD_TRAV = 3'd5
  } cmd_e;
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_RANGE = 2'd2, ST_FULL = 2'd3
  } status_e;
  typedef enum logic [2:0] {
    S_IDLE, S_PASS, S_FREQ, S_FNEXT, S_TRAV
  } state_e;
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  index;
    logic [31:0] element;
    logic [5:0]  count;
    logic        last;
  } res_t;
  typedef struct packed {
    logic [2:0]  command;
    logic [5:0]  position;
    logic [31:0] value;
  } cmd_t;
endpackage

// File: hw/rtl/ale_stream_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a parameter.
interface ale_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ale_cell.sv
// One storage cell of the list chain: holds an entry and its seen mark.
// Depends on nothing; neighbours feed it.
module ale_cell (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [31:0] din_i,
  input  logic        mark_din_i,
  input  logic        mark_clr_i,
  input  logic        rst_ni,
  output logic [31:0] data_o,
  output logic        mark_o
);
  logic [31:0] data_q;
  logic        mark_q;
  always_ff @(posedge clk_i) begin
    if (load_i) data_q <= din_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mark_q <= 1'b0;
    else if (mark_clr_i) mark_q <= 1'b0;
    else if (load_i) mark_q <= mark_din_i;
  end
  assign data_o = data_q;
  assign mark_o = mark_q;
endmodule

// File: hw/rtl/array_list_engine.sv
// Array list engine top level: command sequencer over a chain of cells.
// Depends on ale_pkg, ale_stream_if and ale_cell.
//
// Usage: commands enter on cmd (command, position, value); results leave on
// res. Each defined command yields one result, or one per element/distinct
// value for frequencies and traverse. One command is handled at a time.
// The list lives in a chain of DEPTH cells; a pass rotates the whole chain
// DEPTH times toward cell 0 and rebuilds it through the tail cell.
// Search, insert and delete take one pass, after which the result is
// registered. Remove-all takes one pass per removed copy plus one.
// Errors and frequencies or traverse on an empty list answer in the
// cycle after the transfer. Traverse emits one element per cycle unless
// the receiver stalls. Frequencies rotate the whole chain for each
// candidate element and then decide in S_FNEXT whether to report it.
// Reset empties the list and clears the marks; the store needs no clearing.
// When the receiver stalls, the result holds; traverse holds its rotation
// and frequencies hold before the next candidate. A new command transfers
// in idle once the result register is free, at the earliest in the cycle
// in which the final result transfers.
module array_list_engine #(
  parameter int DEPTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  ale_stream_if.sink   cmd,
  ale_stream_if.source res
);
  localparam int CW = $clog2(DEPTH + 1);

  ale_pkg::state_e state_q, state_d;
  logic [31:0] dat [DEPTH];
  logic        mrk [DEPTH];
  logic [31:0] din [DEPTH];
  logic        mdin [DEPTH];
  logic        mclr;

  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, k_q, k_d, nc_q, nc_d, at_q, at_d;
  logic [2:0]  op_q, op_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] val_q, val_d, key_q, key_d, prev_q, prev_d;
  logic        fnd_q, fnd_d, skip_q, skip_d, rest_q, rest_d;
  ale_pkg::res_t r_q, r_d;
  logic rv_q, rv_d;

  // Head (cell 0) shows the current entry; cell n <- cell n+1, last <- tail.
  logic        rot;
  logic [31:0] tail;
  logic        tail_mark;
  logic        hit;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_t
      assign din[g]  = tail;
      assign mdin[g] = tail_mark;
    end else begin : g_n
      assign din[g]  = dat[g+1];
      assign mdin[g] = mrk[g+1];
    end
    ale_cell u_cell (
      .clk_i, .rst_ni, .load_i(rot), .din_i(din[g]),
      .mark_din_i(mdin[g]), .mark_clr_i(mclr),
      .data_o(dat[g]), .mark_o(mrk[g])
    );
  end

  wire outfree = !rv_q || res.ready;
  assign cmd.ready = (state_q == ale_pkg::S_IDLE) && outfree;
  assign res.valid = rv_q;
  assign res.data = r_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; i_d = i_q; k_d = k_q; nc_d = nc_q; at_d = at_q;
    op_d = op_q; pos_d = pos_q; val_d = val_q; key_d = key_q; prev_d = prev_q;
    fnd_d = fnd_q; skip_d = skip_q; rest_d = rest_q;
    r_d = r_q; rv_d = rv_q && !res.ready;
    rot = 1'b0; tail = dat[0]; tail_mark = mrk[0]; mclr = 1'b0; hit = 1'b0;
    case (state_q)
      ale_pkg::S_IDLE: begin
        if (cmd.valid && cmd.ready) begin
          op_d = cmd.data.command; pos_d = cmd.data.position;
          val_d = cmd.data.value; k_d = '0; i_d = '0; fnd_d = 1'b0;
          skip_d = 1'b0; at_d = '0; nc_d = '0;
          case (cmd.data.command)
            ale_pkg::CMD_SEARCH, ale_pkg::CMD_REMOVE: state_d = ale_pkg::S_PASS;
            ale_pkg::CMD_INSERT: begin
              if (cnt_q >= CW'(DEPTH)) begin
                r_d = '{ale_pkg::ST_FULL, 5'd0, cmd.data.value, 6'(cnt_q), 1'b1};
                rv_d = 1'b1;
              end else if (7'(cmd.data.position) > 7'(cnt_q)) begin
                r_d = '{ale_pkg::ST_RANGE, 5'd0, cmd.data.value, 6'(cnt_q), 1'b1};
                rv_d = 1'b1;
              end else state_d = ale_pkg::S_PASS;
            end
            ale_pkg::CMD_DELETE: begin
              if (7'(cmd.data.position) >= 7'(cnt_q)) begin
                r_d = '{ale_pkg::ST_RANGE, 5'd0, 32'd0, 6'(cnt_q), 1'b1};
                rv_d = 1'b1;
              end else state_d = ale_pkg::S_PASS;
            end
            ale_pkg::CMD_FREQ, ale_pkg::CMD_TRAV: begin
              if (cnt_q == '0) begin
                r_d = '{ale_pkg::ST_NOT_FOUND, 5'd0, 32'd0, 6'd0, 1'b1};
                rv_d = 1'b1;
              end else state_d = (cmd.data.command == ale_pkg::CMD_FREQ) ?
                                 ale_pkg::S_FREQ : ale_pkg::S_TRAV;
            end
            default: ;
          endcase
        end
      end
      // Rotate DEPTH times; the tail takes entry k of the rebuilt list.
      ale_pkg::S_PASS: begin
        rot = 1'b1;
        k_d = k_q + CW'(1);
        prev_d = dat[0];
        case (op_q)
          ale_pkg::CMD_SEARCH: begin
            if (k_q < cnt_q && dat[0] == val_q) begin
              fnd_d = 1'b1; at_d = k_q;
            end
          end
          ale_pkg::CMD_INSERT: begin
            if (k_q == CW'(pos_q)) tail = val_q;
            else if (k_q > CW'(pos_q)) tail = prev_q;
          end
          default: begin
            if (op_q == ale_pkg::CMD_DELETE) hit = (k_q == CW'(pos_q));
            else hit = !skip_q && k_q < cnt_q && dat[0] == val_q;
            if (hit) begin
              key_d = dat[0]; skip_d = 1'b1;
            end
            if ((skip_q || hit) && k_q != CW'(DEPTH - 1)) tail = dat[1];
          end
        endcase
        if (k_q == CW'(DEPTH - 1)) begin
          k_d = '0;
          skip_d = 1'b0;
          state_d = ale_pkg::S_IDLE;
          case (op_q)
            ale_pkg::CMD_SEARCH: begin
              rv_d = 1'b1;
              r_d = '{fnd_d ? ale_pkg::ST_OK : ale_pkg::ST_NOT_FOUND, 5'(at_d),
                      val_q, 6'(cnt_q), 1'b1};
            end
            ale_pkg::CMD_INSERT: begin
              rv_d = 1'b1;
              cnt_d = cnt_q + CW'(1);
              r_d = '{ale_pkg::ST_OK, 5'(pos_q), val_q, 6'(cnt_q + CW'(1)), 1'b1};
            end
            ale_pkg::CMD_DELETE: begin
              rv_d = 1'b1;
              cnt_d = cnt_q - CW'(1);
              r_d = '{ale_pkg::ST_OK, 5'(pos_q), key_d, 6'(cnt_q - CW'(1)), 1'b1};
            end
            default: begin
              if (skip_q || hit) begin
                cnt_d = cnt_q - CW'(1);
                fnd_d = 1'b1;
                state_d = ale_pkg::S_PASS;
              end else begin
                rv_d = 1'b1;
                r_d = '{fnd_q ? ale_pkg::ST_OK : ale_pkg::ST_NOT_FOUND, 5'd0, val_q,
                        6'(cnt_q), 1'b1};
              end
            end
          endcase
        end
      end
      ale_pkg::S_TRAV: begin
        if (outfree) begin
          rot = 1'b1;
          k_d = k_q + CW'(1);
          if (k_q < cnt_q) begin
            r_d = '{ale_pkg::ST_OK, 5'(k_q), dat[0], 6'(cnt_q),
                    k_q + CW'(1) == cnt_q};
            rv_d = 1'b1;
          end
          if (k_q == CW'(DEPTH - 1)) begin
            k_d = '0;
            state_d = ale_pkg::S_IDLE;
          end
        end
      end
      // Candidate i: count and mark later copies; note any unmarked entry left.
      ale_pkg::S_FREQ: begin
        rot = 1'b1;
        k_d = k_q + CW'(1);
        if (k_q == i_q) begin
          key_d = dat[0]; nc_d = CW'(1); fnd_d = mrk[0]; rest_d = 1'b0;
        end else if (k_q > i_q && k_q < cnt_q) begin
          hit = !fnd_q && dat[0] == key_q;
          if (hit) begin
            nc_d = nc_q + CW'(1);
            tail_mark = 1'b1;
          end
          if (!(mrk[0] || hit)) rest_d = 1'b1;
        end
        if (k_q == CW'(DEPTH - 1)) begin
          k_d = '0;
          state_d = ale_pkg::S_FNEXT;
        end
      end
      ale_pkg::S_FNEXT: begin
        if (fnd_q) begin
          i_d = i_q + CW'(1);
          state_d = ale_pkg::S_FREQ;
        end else if (outfree) begin
          rv_d = 1'b1;
          r_d = '{ale_pkg::ST_OK, 5'(i_q), key_q, 6'(nc_q), !rest_q};
          if (!rest_q) begin
            mclr = 1'b1;
            state_d = ale_pkg::S_IDLE;
          end else begin
            i_d = i_q + CW'(1);
            state_d = ale_pkg::S_FREQ;
          end
        end
      end
      default: state_d = ale_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ale_pkg::S_IDLE;
      cnt_q <= '0; rv_q <= 1'b0; k_q <= '0; i_q <= '0; skip_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rv_q <= rv_d;
      k_q <= k_d; i_q <= i_d; skip_q <= skip_d;
    end
  end
  always_ff @(posedge clk_i) begin
    nc_q <= nc_d; op_q <= op_d; pos_q <= pos_d; val_q <= val_d; key_q <= key_d;
    prev_q <= prev_d; fnd_q <= fnd_d; rest_q <= rest_d; at_q <= at_d; r_q <= r_d;
  end
endmodule

// File: hw/rtl/ale_checker.sv
// Port checker for the array list engine, bound to the top level.
// Depends on ale_pkg and the top level's channel interfaces.
module ale_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid, in_ready, out_valid, out_ready,
  input ale_pkg::res_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.count <= 6'd32) else $error("count");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != ale_pkg::ST_OK |-> out_data.last) else $error("last");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid || out_ready) else $error("busy");
endmodule

bind array_list_engine ale_port_checker u_chk (
  .clk_i, .rst_ni, .in_valid(cmd.valid), .in_ready(cmd.ready),
  .out_valid(res.valid), .out_ready(res.ready), .out_data(res.data)
);
